@@ design/bds_pkg.sv @@
// Shared constants and types for the 2x2 box downsampler.
`timescale 1ns / 1ps
`default_nettype none
package bds_pkg;

  localparam int PIX_W     = 8;
  localparam int SUM_W     = 9;   // one horizontal pair sum of a channel
  localparam int NUM_LANES = 4;   // red, green, blue, alpha
  localparam int ROW_W     = 20;
  localparam int ROW_LIMIT = 1048576;

  localparam int WIDTH_REG_W  = 14;
  localparam int HEIGHT_REG_W = 21;
  localparam int CFG_DATA_W   = 21;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_HEIGHT = 1'd1;

  localparam int MAX_WIDTH_DEFAULT = 8192;
  localparam int CHANNELS_DEFAULT  = 4;

  // position of the current source pixel
  typedef struct packed {
    logic odd_col;
    logic odd_row;
    logic last_col;
    logic last_row;
  } pos_t;

  // what the output stage needs to finish one block
  typedef struct packed {
    logic       use_buf;
    logic [1:0] shift;
    logic       row_end;
    logic       frame_end;
  } blk_t;

endpackage
`default_nettype wire

@@ design/bds_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bds_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 4096,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/bds_pos.sv @@
// Size registers and column/row position counters of the source level.
`timescale 1ns / 1ps
`default_nettype none
module bds_pos #(
  parameter int MAX_WIDTH = bds_pkg::MAX_WIDTH_DEFAULT,
  parameter int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [bds_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bds_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                           step,
  output bds_pkg::pos_t                       pos,
  output logic      [COL_W-1:0]               col
);
  import bds_pkg::*;

  logic [COL_W-1:0]        width_last;
  logic [ROW_W-1:0]        height_last;
  logic [COL_W-1:0]        width_last_next;
  logic [ROW_W-1:0]        height_last_next;
  logic [ROW_W-1:0]        row;
  logic [WIDTH_REG_W-1:0]  w;
  logic [HEIGHT_REG_W-1:0] h;
  logic [HEIGHT_REG_W-1:0] h_m1;

  assign w    = cfg_data[WIDTH_REG_W-1:0];
  assign h    = cfg_data[HEIGHT_REG_W-1:0];
  assign h_m1 = h - 1'b1;

  // registers hold the clamped index of the last column / row
  always_comb begin
    if (w == '0) begin
      width_last_next = '0;
    end else if (32'(w) > 32'(MAX_WIDTH)) begin
      width_last_next = COL_W'(MAX_WIDTH - 1);
    end else begin
      width_last_next = COL_W'(w - 1'b1);
    end
    if (h == '0) begin
      height_last_next = '0;
    end else if (32'(h) > 32'(ROW_LIMIT)) begin
      height_last_next = ROW_W'(ROW_LIMIT - 1);
    end else begin
      height_last_next = h_m1[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_last  <= '0;
      height_last <= '0;
    end else if (cfg_write) begin
      if (cfg_index == CFG_SOURCE_WIDTH) begin
        width_last <= width_last_next;
      end
      if (cfg_index == CFG_SOURCE_HEIGHT) begin
        height_last <= height_last_next;
      end
    end
  end

  assign pos.odd_col  = col[0];
  assign pos.odd_row  = row[0];
  assign pos.last_col = (col >= width_last);
  assign pos.last_row = (row >= height_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (step) begin
      if (pos.last_col) begin
        col <= '0;
        row <= pos.last_row ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  a_wrap_frame: assert property (@(posedge clk) disable iff (rst)
    step && pos.last_col && pos.last_row |=> col == '0 && row == '0)
    else $error("position did not wrap at end of level");

  a_col_step: assert property (@(posedge clk) disable iff (rst)
    step && !pos.last_col |=> col == $past(col) + 1'b1 && row == $past(row))
    else $error("column did not advance");

  a_row_step: assert property (@(posedge clk) disable iff (rst)
    step && pos.last_col && !pos.last_row |=> col == '0 && row == $past(row) + 1'b1)
    else $error("row did not advance");

endmodule
`default_nettype wire

@@ design/bds_out.sv @@
// Block finish stage (adds buffered pair sums, rounds) and output register.
`timescale 1ns / 1ps
`default_nettype none
module bds_out #(
  parameter int CHANNELS = bds_pkg::CHANNELS_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  take,
  input  wire bds_pkg::blk_t                         take_info,
  input  wire logic [CHANNELS*bds_pkg::SUM_W-1:0]    take_sums,
  input  wire logic [CHANNELS*bds_pkg::SUM_W-1:0]    buf_sums,
  output logic                                       ready,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [bds_pkg::NUM_LANES-1:0][bds_pkg::PIX_W-1:0] out_pix,
  output logic                                       row_end,
  output logic                                       frame_end
);
  import bds_pkg::*;

  localparam int LANE_W = CHANNELS * SUM_W;

  logic              s1_valid;
  blk_t              s1_info;
  logic [LANE_W-1:0] s1_sums;
  logic              advance;
  logic [NUM_LANES-1:0][PIX_W-1:0] pix_next;

  assign advance = !out_valid || out_ready;
  assign ready   = !s1_valid || advance;

  for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
    if (c < CHANNELS) begin : g_used
      logic [SUM_W+1:0] sum;
      logic [SUM_W+1:0] rnd;
      always_comb begin
        sum = {2'b00, s1_sums[c*SUM_W +: SUM_W]} +
              (s1_info.use_buf ? {2'b00, buf_sums[c*SUM_W +: SUM_W]} : '0);
        case (s1_info.shift)
          2'd0:    rnd = sum;
          2'd1:    rnd = (sum + 1'b1) >> 1;
          2'd2:    rnd = (sum + 2'd2) >> 2;
          default: rnd = sum;
        endcase
        pix_next[c] = (rnd > (SUM_W+2)'(255)) ? 8'hFF : rnd[PIX_W-1:0];
      end
    end else begin : g_unused
      assign pix_next[c] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_info <= take_info;
      s1_sums <= take_sums;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      out_pix   <= pix_next;
      row_end   <= s1_info.row_end;
      frame_end <= s1_info.frame_end;
    end
  end

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_sums))
    else $error("finish stage lost a block while stalled");

  a_busy_full: assert property (@(posedge clk) disable iff (rst)
    !ready |-> s1_valid && out_valid)
    else $error("input stalled with room in the pipe");

  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> row_end)
    else $error("level end without row end");

endmodule
`default_nettype wire

@@ design/box_downsample_2x2_rgba_top.sv @@
// 2x2 box-filter downsampler for RGBA8 pixels: one mipmap level per pass.
//
// Configuration: write source_width (index 0) and source_height (index 1)
// through cfg_write/cfg_index/cfg_data while the block is idle. Both
// reset to 1. Widths above MAX_WIDTH clamp to MAX_WIDTH, zero acts as 1.
// Input: source pixels in raster order on in_valid/in_ready, one request a
// clock. Output: one pixel per 2x2 source block on out_valid/out_ready,
// the rounded mean of its in-bounds pixels, with row_end and frame_end.
// Throughput: one source pixel per clock while out_ready keeps up. A
// result passes the finish stage register, then the output register, once
// the pixel completing its block is accepted. Even rows park horizontal
// pair sums in a line buffer RAM ((MAX_WIDTH+1)/2 entries); the odd row
// below reads them back, one RAM write or read per horizontal pair.
// Reset clears position counters and the pipe; the line buffer needs no
// clearing pass. When out_ready is low the two internal stages fill and
// in_ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module box_downsample_2x2_rgba_top #(
  parameter int MAX_WIDTH = bds_pkg::MAX_WIDTH_DEFAULT,
  parameter int CHANNELS  = bds_pkg::CHANNELS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [bds_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bds_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [bds_pkg::PIX_W-1:0]       red_in,
  input  wire logic [bds_pkg::PIX_W-1:0]       green_in,
  input  wire logic [bds_pkg::PIX_W-1:0]       blue_in,
  input  wire logic [bds_pkg::PIX_W-1:0]       alpha_in,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [bds_pkg::PIX_W-1:0]       red_out,
  output logic      [bds_pkg::PIX_W-1:0]       green_out,
  output logic      [bds_pkg::PIX_W-1:0]       blue_out,
  output logic      [bds_pkg::PIX_W-1:0]       alpha_out,
  output logic                                 row_end,
  output logic                                 frame_end
);
  import bds_pkg::*;

  localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int BUF_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int IDX_W     = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int LANE_W    = CHANNELS * SUM_W;

  logic                            accept;
  pos_t                            pos;
  logic [COL_W-1:0]                col;
  logic [COL_W-1:0]                col_half;
  logic [IDX_W-1:0]                idx;
  logic                            block_done;
  logic                            emit;
  logic                            ram_we;
  logic                            ram_re;
  logic [LANE_W-1:0]               pair_sums;
  logic [LANE_W-1:0]               pair_sums_next;
  logic [LANE_W-1:0]               buf_sums;
  blk_t                            blk;
  logic [NUM_LANES-1:0][PIX_W-1:0] px;
  logic [NUM_LANES-1:0][PIX_W-1:0] out_pix;

  assign px[0] = red_in;
  assign px[1] = green_in;
  assign px[2] = blue_in;
  assign px[3] = alpha_in;

  assign accept = in_valid && in_ready;

  bds_pos #(
    .MAX_WIDTH (MAX_WIDTH),
    .COL_W     (COL_W)
  ) u_pos (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (accept),
    .pos       (pos),
    .col       (col)
  );

  // horizontal pair sum: odd columns add to the sum left by the even one
  for (genvar c = 0; c < CHANNELS; c++) begin : g_pair
    assign pair_sums_next[c*SUM_W +: SUM_W] = {1'b0, px[c]} +
        (pos.odd_col ? pair_sums[c*SUM_W +: SUM_W] : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_sums <= '0;
    end else if (accept) begin
      pair_sums <= pair_sums_next;
    end
  end

  assign col_half   = col >> 1;
  assign idx        = col_half[IDX_W-1:0];
  assign block_done = pos.odd_col || pos.last_col;
  assign emit       = block_done && (pos.odd_row || pos.last_row);
  // even row parks the pair, odd row fetches it; a row always lies between
  assign ram_we     = accept && block_done && !pos.odd_row && !pos.last_row;
  assign ram_re     = accept && block_done && pos.odd_row;

  assign blk.use_buf   = pos.odd_row;
  assign blk.shift     = {1'b0, pos.odd_col} + {1'b0, pos.odd_row};
  assign blk.row_end   = pos.last_col;
  assign blk.frame_end = pos.last_col && pos.last_row;

  bds_ram #(
    .WIDTH  (LANE_W),
    .DEPTH  (BUF_DEPTH),
    .ADDR_W (IDX_W)
  ) u_line_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata (pair_sums_next),
    .re    (ram_re),
    .raddr (idx),
    .rdata (buf_sums)
  );

  bds_out #(
    .CHANNELS (CHANNELS)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .take      (accept && emit),
    .take_info (blk),
    .take_sums (pair_sums_next),
    .buf_sums  (buf_sums),
    .ready     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pix   (out_pix),
    .row_end   (row_end),
    .frame_end (frame_end)
  );

  assign red_out   = out_pix[0];
  assign green_out = out_pix[1];
  assign blue_out  = out_pix[2];
  assign alpha_out = out_pix[3];

  a_ram_one_port: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("line buffer read and write in one cycle");

  a_read_emits: assert property (@(posedge clk) disable iff (rst)
    ram_re |-> emit)
    else $error("line buffer read without a result");

  a_read_stable: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> $stable(buf_sums))
    else $error("buffered sums changed while stalled");

endmodule
`default_nettype wire

@@ bench/tb_box_downsample_2x2_rgba_top.sv @@
// Self-checking testbench for the 2x2 RGBA box downsampler top level.
`timescale 1ns / 1ps
module tb_box_downsample_2x2_rgba_top;
  import bds_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int MAX_W         = MAX_WIDTH_DEFAULT;
  localparam int RANDOM_ITEMS  = 400;
  localparam int SETTLE_CYCLES = 6;     // two pipe stages plus margin
  localparam int MAX_REPORTS   = 10;
  // ~500 pixels with random input gaps, their results with random output
  // stalls, plus drains around every register write
  localparam int CYCLE_LIMIT   = 200_000;

  // lane 0 is red, lane 3 alpha: literals read 32'hAABBGGRR
  typedef logic [NUM_LANES-1:0][PIX_W-1:0] rgba_t;

  typedef struct packed {
    rgba_t px;
    logic  row_end;
    logic  frame_end;
  } box_px_t;

  typedef struct packed {
    logic                   is_cfg;
    logic [CFG_INDEX_W-1:0] reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    rgba_t                  px;
    logic                   known;
    box_px_t                want;
  } plan_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [PIX_W-1:0]       red_in = '0;
  logic [PIX_W-1:0]       green_in = '0;
  logic [PIX_W-1:0]       blue_in = '0;
  logic [PIX_W-1:0]       alpha_in = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [PIX_W-1:0]       red_out;
  logic [PIX_W-1:0]       green_out;
  logic [PIX_W-1:0]       blue_out;
  logic [PIX_W-1:0]       alpha_out;
  logic                   row_end;
  logic                   frame_end;

  box_downsample_2x2_rgba_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .alpha_in  (alpha_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .alpha_out (alpha_out),
    .row_end   (row_end),
    .frame_end (frame_end)
  );

  always #HALF_PERIOD clk = ~clk;

  // downsampler state as the bench sees it
  logic [WIDTH_REG_W-1:0]  src_width_reg = 1;
  logic [HEIGHT_REG_W-1:0] src_height_reg = 1;
  int                      col_pos = 0;
  int                      row_pos = 0;
  logic [NUM_LANES-1:0][SUM_W-1:0] pair_acc = '0;
  logic [NUM_LANES-1:0][SUM_W-1:0] held_pairs [MAX_W/2];

  box_px_t expected_px [$];
  int      error_count = 0;
  int      cycle_count = 0;
  int      send_calm = 0;
  int      recv_calm = 0;

  function automatic int eff_width();
    if (src_width_reg == 0) return 1;
    if (src_width_reg > MAX_W) return MAX_W;
    return int'(src_width_reg);
  endfunction

  function automatic int eff_height();
    if (src_height_reg == 0) return 1;
    if (src_height_reg > ROW_LIMIT) return ROW_LIMIT;
    return int'(src_height_reg);
  endfunction

  // Advances the position by one source pixel; returns 1 when a block completes with a result due.
  function automatic bit average_block(input rgba_t px, output box_px_t res);
    bit last_col;
    bit last_row;
    bit odd_col;
    bit emit;
    int idx;
    int shift;
    int v;
    int totals [NUM_LANES];
    logic [NUM_LANES-1:0][SUM_W-1:0] lane_sum;
    last_col = col_pos >= eff_width() - 1;
    last_row = row_pos >= eff_height() - 1;
    odd_col  = (col_pos & 1) != 0;
    emit     = 1'b0;
    shift    = 0;
    for (int c = 0; c < NUM_LANES; c++) begin
      lane_sum[c] = SUM_W'(px[c]) + (odd_col ? pair_acc[c] : '0);
      totals[c]   = 0;
    end
    pair_acc = lane_sum;
    if (odd_col || last_col) begin
      idx   = col_pos >> 1;
      shift = odd_col ? 1 : 0;
      if ((row_pos & 1) == 0) begin
        if (last_row) begin
          emit = 1'b1;
          for (int c = 0; c < NUM_LANES; c++) totals[c] = int'(lane_sum[c]);
        end else begin
          held_pairs[idx] = lane_sum;
        end
      end else begin
        emit  = 1'b1;
        shift = shift + 1;
        for (int c = 0; c < NUM_LANES; c++)
          totals[c] = int'(lane_sum[c]) + int'(held_pairs[idx][c]);
      end
    end
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    for (int c = 0; c < NUM_LANES; c++) begin
      v = (totals[c] + ((1 << shift) >> 1)) >> shift;
      if (v > 255) v = 255;
      res.px[c] = PIX_W'(v);
    end
    res.row_end   = last_col;
    res.frame_end = last_col && last_row;
    return emit;
  endfunction

  function automatic plan_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic plan_row_t px_row(rgba_t px);
    plan_row_t r;
    r    = '0;
    r.px = px;
    return r;
  endfunction

  function automatic plan_row_t px_known(rgba_t px, rgba_t want_px, logic re, logic fe);
    plan_row_t r;
    r       = '0;
    r.px    = px;
    r.known = 1'b1;
    r.want  = {want_px, re, fe};
    return r;
  endfunction

  plan_row_t directed_plan [23] = '{
    // after reset the level is 1x1: each pixel comes straight through
    px_known(32'h00000000, 32'h00000000, 1'b1, 1'b1),
    px_known(32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1),
    px_known(32'h78563412, 32'h78563412, 1'b1, 1'b1),
    // zero size acts as one
    cfg_row(CFG_SOURCE_WIDTH, 21'd0),
    cfg_row(CFG_SOURCE_HEIGHT, 21'd0),
    px_known(32'h3CC35AA5, 32'h3CC35AA5, 1'b1, 1'b1),
    // one full 2x2 block: blue rounds up, alpha rounds down
    cfg_row(CFG_SOURCE_WIDTH, 21'd2),
    cfg_row(CFG_SOURCE_HEIGHT, 21'd2),
    px_row(32'h010100FF),
    px_row(32'h000100FF),
    px_row(32'h000000FF),
    px_known(32'h000000FF, 32'h000100FF, 1'b1, 1'b1),
    // 3x3: odd last column, odd last row and the single-pixel corner;
    // bits above the width register are don't-care
    cfg_row(CFG_SOURCE_WIDTH, 21'h1FC003),
    cfg_row(CFG_SOURCE_HEIGHT, 21'd3),
    px_row(32'hFFFFFFFF),
    px_row(32'h00000000),
    px_row(32'h80808080),
    px_row(32'h7F7F7F7F),
    px_row(32'h01FE01FE),
    px_row(32'hFF00FF00),
    px_row(32'h12345678),
    px_row(32'h9ABCDEF0),
    px_row(32'h0F0F0F0F)
  };

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
  endfunction

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic rgba_t random_pixel();
    rgba_t px;
    for (int c = 0; c < NUM_LANES; c++) begin
      case ($urandom_range(0, 7))
        0:       px[c] = '0;
        1:       px[c] = '1;
        default: px[c] = PIX_W'($urandom_range(0, 255));
      endcase
    end
    return px;
  endfunction

  task automatic send_pixel(input rgba_t px, input bit known, input box_px_t want);
    int      gap;
    box_px_t res;
    gap = draw_gap(send_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {alpha_in, blue_in, green_in, red_in} <= px;
    do @(posedge clk); while (!(in_valid && in_ready));
    if (average_block(px, res)) expected_px = {expected_px, (known ? want : res)};
  endtask

  // hold off new requests until every pending block has come out
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == CFG_SOURCE_WIDTH) src_width_reg = val[WIDTH_REG_W-1:0];
    else src_height_reg = val[HEIGHT_REG_W-1:0];
    cfg_write <= 1'b0;
  endtask

  task automatic feed(input int count);
    repeat (count) send_pixel(random_pixel(), 1'b0, '0);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               expected_px.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin
    box_px_t got;
    box_px_t want;
    if (!rst && out_valid && out_ready) begin
      got = {alpha_out, blue_out, green_out, red_out, row_end, frame_end};
      if (expected_px.size() == 0) begin
        flag_error($sformatf("unexpected result rgba %h", got.px));
      end else begin
        want = expected_px.pop_front();
        if (got !== want)
          flag_error($sformatf({"got r%h g%h b%h a%h row_end %b frame_end %b, ",
                                "expected r%h g%h b%h a%h row_end %b frame_end %b"},
                               got.px[0], got.px[1], got.px[2], got.px[3],
                               got.row_end, got.frame_end,
                               want.px[0], want.px[1], want.px[2], want.px[3],
                               want.row_end, want.frame_end));
      end
    end
  end

  // output side: random stalls per result, with calm stretches
  initial begin
    int stall;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      stall = draw_gap(recv_calm);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    int random_px;
    int w;
    int h;
    random_px = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg)
        write_reg(directed_plan[i].reg_idx, directed_plan[i].reg_val);
      else
        send_pixel(directed_plan[i].px, directed_plan[i].known, directed_plan[i].want);
    end

    // tall levels cut short on an even row
    write_reg(CFG_SOURCE_WIDTH, 21'd5);
    write_reg(CFG_SOURCE_HEIGHT, 21'h1FFFFF);
    feed(20);
    write_reg(CFG_SOURCE_HEIGHT, 21'd5);
    feed(5);
    write_reg(CFG_SOURCE_WIDTH, 21'd3);
    write_reg(CFG_SOURCE_HEIGHT, CFG_DATA_W'(ROW_LIMIT));
    feed(6);
    write_reg(CFG_SOURCE_HEIGHT, 21'd3);
    feed(3);

    // width shrunk at a row boundary, then inside a row
    write_reg(CFG_SOURCE_WIDTH, 21'd6);
    write_reg(CFG_SOURCE_HEIGHT, 21'd6);
    feed(12);
    write_reg(CFG_SOURCE_WIDTH, 21'd4);
    feed(16);
    write_reg(CFG_SOURCE_WIDTH, 21'd8);
    write_reg(CFG_SOURCE_HEIGHT, 21'd1);
    feed(5);
    write_reg(CFG_SOURCE_WIDTH, 21'd3);
    feed(1);

    // random small levels; junk above the width register bits
    while (random_px < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      write_reg(CFG_SOURCE_WIDTH,
                CFG_DATA_W'(w) | (CFG_DATA_W'($urandom()) << WIDTH_REG_W));
      write_reg(CFG_SOURCE_HEIGHT, CFG_DATA_W'(h));
      feed(w * h);
      random_px += w * h;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
